[sv/assert_macros.svh]
// Assertion macros shared by the accumulator RTL.
// Each macro expects clk and arst_n to exist in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/wma_pkg.sv]
// Package for the weighted moment accumulator: payload structs, request and
// status codes, and the request/response types of the shared divide/root unit.
package wma_pkg;

	localparam int COUNT_BITS_DEF = 16;

	localparam logic [1:0] REQ_FILL  = 2'd0;
	localparam logic [1:0] REQ_QUERY = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_NO_WEIGHT = 3'd1;
	localparam logic [2:0] STAT_ONE_ENTRY = 3'd2;
	localparam logic [2:0] STAT_DEN_ZERO  = 3'd3;
	localparam logic [2:0] STAT_UNSTABLE  = 3'd4;
	localparam logic [2:0] STAT_FILL_IGN  = 3'd5;
	localparam logic [2:0] STAT_NEG_SQ    = 3'd6;

	localparam logic [1:0] CFG_NEFF_TOL = 2'd0;
	localparam logic [1:0] CFG_DEN_TOL  = 2'd1;
	localparam logic [1:0] CFG_UNSTABLE = 2'd2;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [15:0] sample_value;
		logic signed [15:0] sample_weight;
	} wma_in_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [15:0]        fill_count;
		logic signed [47:0] mean_out;
		logic signed [63:0] variance_out;
		logic [47:0]        std_error_out;
		logic [31:0]        rms_out;
		logic [32:0]        eff_entries_out;
	} wma_out_t;

	typedef struct packed {
		logic         start;
		logic         op_sqrt;
		logic [127:0] dividend;
		logic [63:0]  divisor;
	} wma_unit_req_t;

	typedef struct packed {
		logic         done;
		logic [127:0] quot;
		logic [63:0]  root;
	} wma_unit_rsp_t;

endpackage

[sv/wma_divsqrt.sv]
// Shared radix-2 unit: restoring division of a 128-bit dividend by a 64-bit
// divisor, or integer square root of a 128-bit radicand. Uses wma_pkg types.
`include "assert_macros.svh"

module wma_divsqrt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wma_pkg::wma_unit_req_t ureq,
	output wma_pkg::wma_unit_rsp_t ursp
);

	localparam int RW = 68;
	localparam logic [6:0] DIV_LAST  = 7'd127;
	localparam logic [6:0] SQRT_LAST = 7'd63;

	logic          busy_q;
	logic          done_q;
	logic          op_q;
	logic [6:0]    cnt_q;
	logic [127:0]  num_q;
	logic [RW-1:0] rem_q;
	logic [63:0]   root_q;
	logic [63:0]   d_q;

	logic [RW-1:0] r2;
	logic [RW-1:0] trial;
	logic [RW:0]   diff;
	logic          ge;
	logic [RW-1:0] rem_n;

	// One compare-subtract serves both operations: the trial value is the
	// divisor for division and 4*root+1 for the square root.
	always_comb begin
		if (op_q) begin
			r2    = {rem_q[RW-3:0], num_q[127:126]};
			trial = {2'b00, root_q, 2'b01};
		end else begin
			r2    = {rem_q[RW-2:0], num_q[127]};
			trial = {4'b0000, d_q};
		end
		diff  = {1'b0, r2} - {1'b0, trial};
		ge    = !diff[RW];
		rem_n = ge ? diff[RW-1:0] : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
			d_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (ureq.start) begin
				busy_q <= 1'b1;
				op_q   <= ureq.op_sqrt;
				cnt_q  <= ureq.op_sqrt ? SQRT_LAST : DIV_LAST;
				num_q  <= ureq.dividend;
				d_q    <= ureq.divisor;
				rem_q  <= '0;
				root_q <= '0;
			end else if (busy_q) begin
				rem_q <= rem_n;
				if (op_q) begin
					num_q  <= {num_q[125:0], 2'b00};
					root_q <= {root_q[62:0], ge};
				end else begin
					num_q <= {num_q[126:0], ge};
				end
				if (cnt_q == 7'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 7'd1;
				end
			end
		end
	end

	assign ursp.done = done_q;
	assign ursp.quot = num_q;
	assign ursp.root = root_q;

	`ASSERT_ALWAYS(a_start_idle, ureq.start |-> !busy_q, "unit started while busy")
	`ASSERT_NEXT(a_done_last, busy_q && !ureq.start && cnt_q == 7'd0,
		done_q && !busy_q, "unit did not finish on its last step")

endmodule

[sv/weighted_moment_accumulator_unit.sv]
// Weighted moment accumulator top level: accumulators, sequencer, shared
// 32x32 multiplier. Uses wma_pkg and the wma_divsqrt divide/root unit.
//
// Usage: requests arrive on req (valid/ready). A fill adds a weighted sample
// to the running sums, a query turns the sums into mean, variance, standard
// error, rms and effective entries, a clear zeroes the sums. Every request
// gives exactly one response transaction on rsp (valid/ready).
// Configuration registers are written through cfg_write/cfg_index/cfg_data;
// the user must write them only while the block is idle, which the block itself does not enforce; index 3 is ignored.
// Sequencing: a fill passes through S_FILL to S_DONE, a clear or a fill on a
// full count goes straight to S_DONE. A query runs seven multiplier steps,
// then up to five 128-step divisions and two 64-step roots on the single
// radix-2 unit; a query with no net weight goes straight to S_DONE. One
// request is in work at a time: req_ready is high only while the sequencer
// is idle, so a new request is taken only after the last one has finished.
// The response sits in an output register; a new request is taken while it
// waits, and the sequencer holds its next result until the old one is taken.
// Reset clears the sums and fill count and loads the register defaults.

`include "assert_macros.svh"

module weighted_moment_accumulator_unit #(
	parameter int COUNT_BITS = wma_pkg::COUNT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  wma_pkg::wma_in_t req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output wma_pkg::wma_out_t rsp,
	input  logic             cfg_write,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_FILL, S_MUL, S_PREP, S_NEFF, S_MEAN, S_CLASS, S_VAR,
		S_SEDIV, S_SESQ, S_RMSCHK, S_RMSDIV, S_RMSSQ, S_DONE
	} state_t;

	localparam logic [2:0] MSTEP_LAST = 3'd6;

	state_t state_q;

	// Configuration.
	logic [15:0] neff_tol_q;
	logic [31:0] dz_tol_q;
	logic [31:0] ul_q;

	// Running sums (two's complement where signed).
	logic [COUNT_BITS-1:0] fill_total_q;
	logic [31:0] sum_w_q;
	logic [45:0] sum_wsq_q;
	logic [46:0] sum_wx_q;
	logic [61:0] sum_wxx_q;

	// Fill pipeline.
	logic signed [15:0] w_s1;
	logic [31:0] ww_s1;
	logic [31:0] wx_s1;
	logic [30:0] xx_s1;

	// Query working registers.
	logic [31:0]  sm_q;
	logic [46:0]  am_q;
	logic [61:0]  bm_q;
	logic         a_neg_q;
	logic         s_neg_q;
	logic         bs_neg_q;
	logic         b_nz_q;
	logic [2:0]   mstep_q;
	logic [63:0]  mul_q;
	logic [61:0]  ss_q;
	logic [127:0] acc_q;
	logic [63:0]  dm_q;
	logic         den_neg_q;
	logic         num_neg_q;
	logic [127:0] num_mag_q;
	logic [127:0] res_q;
	logic         launched_q;

	// Result fields.
	logic [2:0]  status_q;
	logic [47:0] mean_q;
	logic [63:0] var_q;
	logic [47:0] se_q;
	logic [31:0] rms_q;
	logic [32:0] neff_q;

	logic              rsp_valid_q;
	wma_pkg::wma_out_t rsp_q;

	wma_pkg::wma_unit_req_t ureq;
	wma_pkg::wma_unit_rsp_t ursp;

	logic signed [31:0] ww_c;
	logic signed [31:0] wx_c;
	logic signed [31:0] xx_c;
	logic signed [47:0] wxx_c;
	logic [31:0]  sm_c;
	logic [46:0]  am_c;
	logic [61:0]  bm_c;
	logic [31:0]  mul_a;
	logic [31:0]  mul_b;
	logic [127:0] term;
	logic         term_sub;
	logic [127:0] acc_n;
	logic [63:0]  den_c;
	logic         unit_state;
	logic         mean_neg;
	logic [47:0]  mean_lim;
	logic [47:0]  mean_mag;
	logic [47:0]  mean_c;
	logic         var_neg;
	logic [63:0]  var_lim;
	logic [63:0]  var_mag;
	logic [63:0]  var_c;
	logic         neff_one;
	logic         den_zero;
	logic         unstable;
	logic         out_free;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || rsp_ready;

	always_comb begin
		ww_c  = 32'($signed(req.sample_weight)) * 32'($signed(req.sample_weight));
		wx_c  = 32'($signed(req.sample_weight)) * 32'($signed(req.sample_value));
		xx_c  = 32'($signed(req.sample_value)) * 32'($signed(req.sample_value));
		wxx_c = 48'(w_s1) * 48'($signed({1'b0, xx_s1}));

		sm_c = sum_w_q[31] ? (~sum_w_q + 32'd1) : sum_w_q;
		am_c = sum_wx_q[46] ? (~sum_wx_q + 47'd1) : sum_wx_q;
		bm_c = sum_wxx_q[61] ? (~sum_wxx_q + 62'd1) : sum_wxx_q;
	end

	// Multiplier schedule: S*S, then B*S in two halves, then A*A in three partial
	// products. S*S is kept in ss_q; the others fold into acc in the next cycle.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (mstep_q)
			3'd0: begin
				mul_a = sm_q;
				mul_b = sm_q;
			end
			3'd1: begin
				mul_a = bm_q[31:0];
				mul_b = sm_q;
			end
			3'd2: begin
				mul_a = {2'b00, bm_q[61:32]};
				mul_b = sm_q;
			end
			3'd3: begin
				mul_a = am_q[31:0];
				mul_b = am_q[31:0];
			end
			3'd4: begin
				mul_a = am_q[31:0];
				mul_b = {17'b0, am_q[46:32]};
			end
			3'd5: begin
				mul_a = {17'b0, am_q[46:32]};
				mul_b = {17'b0, am_q[46:32]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase

		term     = '0;
		term_sub = 1'b0;
		case (mstep_q)
			3'd2: begin
				term     = {64'b0, mul_q};
				term_sub = bs_neg_q;
			end
			3'd3: begin
				term     = {32'b0, mul_q, 32'b0};
				term_sub = bs_neg_q;
			end
			3'd4: begin
				term     = {64'b0, mul_q};
				term_sub = 1'b1;
			end
			3'd5: begin
				// The cross term appears twice, hence the extra bit of shift.
				term     = {31'b0, mul_q, 33'b0};
				term_sub = 1'b1;
			end
			3'd6: begin
				term     = {mul_q, 64'b0};
				term_sub = 1'b1;
			end
			default: begin
				term     = '0;
				term_sub = 1'b0;
			end
		endcase
		acc_n = acc_q + (term ^ {128{term_sub}}) + {127'b0, term_sub};
		den_c = {2'b00, ss_q} - {18'b0, sum_wsq_q};
	end

	always_comb begin
		unit_state = (state_q == S_NEFF) || (state_q == S_MEAN) || (state_q == S_VAR) ||
			(state_q == S_SEDIV) || (state_q == S_SESQ) || (state_q == S_RMSDIV) ||
			(state_q == S_RMSSQ);
		ureq.start   = unit_state && !launched_q;
		ureq.op_sqrt = (state_q == S_SESQ) || (state_q == S_RMSSQ);
		ureq.dividend = res_q;
		ureq.divisor  = {32'b0, sm_q};
		case (state_q)
			S_NEFF: begin
				ureq.dividend = {50'b0, ss_q, 16'b0};
				ureq.divisor  = {18'b0, sum_wsq_q};
			end
			S_MEAN: begin
				ureq.dividend = {65'b0, am_q, 16'b0};
				ureq.divisor  = {32'b0, sm_q};
			end
			S_VAR: begin
				ureq.dividend = {num_mag_q[111:0], 16'b0};
				ureq.divisor  = dm_q;
			end
			S_SEDIV: begin
				ureq.dividend = {32'b0, var_q, 32'b0};
				ureq.divisor  = {31'b0, neff_q};
			end
			S_RMSDIV: begin
				ureq.dividend = {34'b0, bm_q, 32'b0};
				ureq.divisor  = {32'b0, sm_q};
			end
			default: begin
				ureq.dividend = res_q;
				ureq.divisor  = {32'b0, sm_q};
			end
		endcase
	end

	// Saturating signed quotients and the query class tests.
	always_comb begin
		mean_neg = a_neg_q ^ s_neg_q;
		mean_lim = mean_neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
		mean_mag = ((|ursp.quot[127:48]) || (ursp.quot[47:0] > mean_lim)) ?
			mean_lim : ursp.quot[47:0];
		mean_c = mean_neg ? (~mean_mag + 48'd1) : mean_mag;

		var_neg = num_neg_q ^ den_neg_q;
		var_lim = var_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		var_mag = ((|ursp.quot[127:64]) || (ursp.quot[63:0] > var_lim)) ?
			var_lim : ursp.quot[63:0];
		var_c = var_neg ? (~var_mag + 64'd1) : var_mag;

		neff_one = {1'b0, neff_q} <= (34'h1_0000 + {18'b0, neff_tol_q});
		den_zero = dm_q <= {32'b0, dz_tol_q};
		unstable = (num_mag_q[127:64] == 64'd0) && (num_mag_q[63:0] < {32'b0, ul_q}) &&
			(dm_q < {32'b0, ul_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			neff_tol_q   <= 16'd1;
			dz_tol_q     <= 32'd0;
			ul_q         <= 32'd1;
			fill_total_q <= '0;
			sum_w_q      <= '0;
			sum_wsq_q    <= '0;
			sum_wx_q     <= '0;
			sum_wxx_q    <= '0;
			w_s1         <= '0;
			ww_s1        <= '0;
			wx_s1        <= '0;
			xx_s1        <= '0;
			sm_q         <= '0;
			am_q         <= '0;
			bm_q         <= '0;
			a_neg_q      <= 1'b0;
			s_neg_q      <= 1'b0;
			bs_neg_q     <= 1'b0;
			b_nz_q       <= 1'b0;
			mstep_q      <= '0;
			mul_q        <= '0;
			ss_q         <= '0;
			acc_q        <= '0;
			dm_q         <= '0;
			den_neg_q    <= 1'b0;
			num_neg_q    <= 1'b0;
			num_mag_q    <= '0;
			res_q        <= '0;
			launched_q   <= 1'b0;
			status_q     <= wma_pkg::STAT_OK;
			mean_q       <= '0;
			var_q        <= '0;
			se_q         <= '0;
			rms_q        <= '0;
			neff_q       <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					wma_pkg::CFG_NEFF_TOL: neff_tol_q <= cfg_data[15:0];
					wma_pkg::CFG_DEN_TOL:  dz_tol_q   <= cfg_data;
					wma_pkg::CFG_UNSTABLE: ul_q       <= cfg_data;
					default: ;
				endcase
			end

			// A result loaded in this cycle keeps the output valid.
			if (rsp_valid_q && rsp_ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end

			if (ureq.start) begin
				launched_q <= 1'b1;
			end
			if (ursp.done) begin
				launched_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						mean_q   <= '0;
						var_q    <= '0;
						se_q     <= '0;
						rms_q    <= '0;
						neff_q   <= '0;
						unique case (req.req_type)
							wma_pkg::REQ_FILL: begin
								if (&fill_total_q) begin
									status_q <= wma_pkg::STAT_FILL_IGN;
									state_q  <= S_DONE;
								end else begin
									status_q <= wma_pkg::STAT_OK;
									w_s1    <= req.sample_weight;
									ww_s1   <= ww_c;
									wx_s1   <= wx_c;
									xx_s1   <= xx_c[30:0];
									state_q <= S_FILL;
								end
							end
							wma_pkg::REQ_QUERY: begin
								sm_q     <= sm_c;
								am_q     <= am_c;
								bm_q     <= bm_c;
								s_neg_q  <= sum_w_q[31];
								a_neg_q  <= sum_wx_q[46];
								bs_neg_q <= sum_wxx_q[61] ^ sum_w_q[31];
								b_nz_q   <= |sum_wxx_q;
								if ((sum_w_q == 32'd0) || (sum_wsq_q == 46'd0)) begin
									status_q <= wma_pkg::STAT_NO_WEIGHT;
									state_q  <= S_DONE;
								end else begin
									status_q <= wma_pkg::STAT_OK;
									mstep_q <= '0;
									acc_q   <= '0;
									state_q <= S_MUL;
								end
							end
							wma_pkg::REQ_CLEAR: begin
								status_q     <= wma_pkg::STAT_OK;
								fill_total_q <= '0;
								sum_w_q      <= '0;
								sum_wsq_q    <= '0;
								sum_wx_q     <= '0;
								sum_wxx_q    <= '0;
								state_q      <= S_DONE;
							end
							default: begin
								status_q <= wma_pkg::STAT_OK;
								state_q  <= S_DONE;
							end
						endcase
					end
				end
				S_FILL: begin
					fill_total_q <= fill_total_q + COUNT_BITS'(1);
					sum_w_q      <= sum_w_q + {{16{w_s1[15]}}, w_s1};
					sum_wsq_q    <= sum_wsq_q + {14'b0, ww_s1};
					sum_wx_q     <= sum_wx_q + {{15{wx_s1[31]}}, wx_s1};
					sum_wxx_q    <= sum_wxx_q + {{14{wxx_c[47]}}, wxx_c};
					state_q      <= S_DONE;
				end
				S_MUL: begin
					mul_q <= 64'(mul_a) * 64'(mul_b);
					if (mstep_q == 3'd1) begin
						ss_q <= mul_q[61:0];
					end
					if (mstep_q >= 3'd2) begin
						acc_q <= acc_n;
					end
					if (mstep_q == MSTEP_LAST) begin
						state_q <= S_PREP;
					end else begin
						mstep_q <= mstep_q + 3'd1;
					end
				end
				S_PREP: begin
					den_neg_q <= den_c[63];
					dm_q      <= den_c[63] ? (~den_c + 64'd1) : den_c;
					num_neg_q <= acc_q[127];
					num_mag_q <= acc_q[127] ? (~acc_q + 128'd1) : acc_q;
					state_q   <= S_NEFF;
				end
				S_NEFF: begin
					if (ursp.done) begin
						neff_q  <= (|ursp.quot[127:33]) ? {33{1'b1}} : ursp.quot[32:0];
						state_q <= S_MEAN;
					end
				end
				S_MEAN: begin
					if (ursp.done) begin
						mean_q  <= mean_c;
						state_q <= S_CLASS;
					end
				end
				S_CLASS: begin
					if (neff_one) begin
						status_q <= wma_pkg::STAT_ONE_ENTRY;
						state_q  <= S_RMSCHK;
					end else if (den_zero) begin
						status_q <= wma_pkg::STAT_DEN_ZERO;
						state_q  <= S_RMSCHK;
					end else if (unstable) begin
						status_q <= wma_pkg::STAT_UNSTABLE;
						state_q  <= S_RMSCHK;
					end else begin
						state_q <= S_VAR;
					end
				end
				S_VAR: begin
					if (ursp.done) begin
						var_q <= var_c;
						// The standard error only exists for a positive variance.
						if (!var_c[63] && (|var_c)) begin
							state_q <= S_SEDIV;
						end else begin
							state_q <= S_RMSCHK;
						end
					end
				end
				S_SEDIV: begin
					if (ursp.done) begin
						res_q   <= ursp.quot;
						state_q <= S_SESQ;
					end
				end
				S_SESQ: begin
					if (ursp.done) begin
						se_q    <= (|ursp.root[63:48]) ? {48{1'b1}} : ursp.root[47:0];
						state_q <= S_RMSCHK;
					end
				end
				S_RMSCHK: begin
					if (!b_nz_q) begin
						state_q <= S_DONE;
					end else if (bs_neg_q) begin
						if (status_q == wma_pkg::STAT_OK) begin
							status_q <= wma_pkg::STAT_NEG_SQ;
						end
						state_q <= S_DONE;
					end else begin
						state_q <= S_RMSDIV;
					end
				end
				S_RMSDIV: begin
					if (ursp.done) begin
						res_q   <= ursp.quot;
						state_q <= S_RMSSQ;
					end
				end
				S_RMSSQ: begin
					if (ursp.done) begin
						rms_q   <= (|ursp.root[63:32]) ? {32{1'b1}} : ursp.root[31:0];
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						rsp_q.status          <= status_q;
						rsp_q.fill_count      <= 16'(fill_total_q);
						rsp_q.mean_out        <= mean_q;
						rsp_q.variance_out    <= var_q;
						rsp_q.std_error_out   <= se_q;
						rsp_q.rms_out         <= rms_q;
						rsp_q.eff_entries_out <= neff_q;
						rsp_valid_q           <= 1'b1;
						state_q               <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	wma_divsqrt u_divsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.ureq   (ureq),
		.ursp   (ursp)
	);

	`ASSERT_ALWAYS(a_ready_unit_free, req_ready |-> !launched_q,
		"unit busy while accepting a request")
	`ASSERT_NEXT(a_full_holds,
		req_valid && req_ready && req.req_type == wma_pkg::REQ_FILL && (&fill_total_q),
		fill_total_q == $past(fill_total_q) && state_q == S_DONE,
		"fill on a full count changed state")
	`ASSERT_NEXT(a_done_loads, state_q == S_DONE && out_free,
		rsp_valid_q && state_q == S_IDLE, "finished result not loaded")

endmodule
